@@ hw/rtl/slipcrc_pkg.sv @@
// Shared constants, types and the CRC byte update for the SLIP CRC-16 frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package slipcrc_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int LEN_W     = 9;
    localparam int LEN_CAP   = 511;
    localparam int CMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int HDR_N     = 6;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    localparam logic [15:0] CRC16_POLY = 16'hA001;
    localparam logic [15:0] CRC16_SEED = 16'hFFFF;

    localparam logic [7:0] TYPE_GET    = 8'h06;
    localparam logic [7:0] TYPE_NOTIFY = 8'h07;
    localparam logic [7:0] TYPE_ACK    = 8'h05;

    typedef enum logic [1:0] {
        CLASS_GET    = 2'd0,
        CLASS_NOTIFY = 2'd1,
        CLASS_ACK    = 2'd2,
        CLASS_OTHER  = 2'd3
    } msg_class_t;

    typedef enum logic {
        KIND_BYTE   = 1'b0,
        KIND_REPORT = 1'b1
    } result_kind_t;

    typedef struct packed {
        result_kind_t     kind;
        logic [7:0]       data_byte;
        logic             frame_ok;
        logic [LEN_W-1:0] frame_length;
        msg_class_t       msg_class;
        logic [7:0]       seq_number;
        logic [7:0]       opcode;
        logic [15:0]      payload_length;
        logic             overflow;
    } result_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/slipcrc_frame.sv @@
// Frame state: SLIP unescaping, running CRC, body count and header capture.
`timescale 1ns / 1ps
`default_nettype none

module slipcrc_frame (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [7:0]           byte_in,
    output logic                      res_valid,
    output slipcrc_pkg::result_t      res
);

    logic                           esc_reg, esc_next;
    logic [15:0]                    crc_reg, crc_next;
    logic [slipcrc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]                     hdr_reg [slipcrc_pkg::HDR_N];
    logic [7:0]                     hdr_next [slipcrc_pkg::HDR_N];
    logic                           ovf_reg, ovf_next;

    logic                           emit;
    logic                           report;
    logic                           clear;
    logic [7:0]                     body_byte;
    logic [slipcrc_pkg::CMP_W-1:0]  cnt_ext;
    logic [slipcrc_pkg::LEN_W-1:0]  len;
    slipcrc_pkg::msg_class_t        cls;

    always_comb
    begin
        emit      = 1'b0;
        report    = 1'b0;
        clear     = 1'b0;
        body_byte = byte_in;
        esc_next  = esc_reg;
        priority if (esc_reg)
        begin
            esc_next = 1'b0;
            if (byte_in == slipcrc_pkg::SLIP_ESC_END)
            begin
                emit      = 1'b1;
                body_byte = slipcrc_pkg::SLIP_END;
            end
            else if (byte_in == slipcrc_pkg::SLIP_ESC_ESC)
            begin
                emit      = 1'b1;
                body_byte = slipcrc_pkg::SLIP_ESC;
            end
        end
        else if (byte_in == slipcrc_pkg::SLIP_ESC)
        begin
            esc_next = 1'b1;
        end
        else if (byte_in == slipcrc_pkg::SLIP_END)
        begin
            report = (cnt_reg != '0);
            clear  = 1'b1;
        end
        else
        begin
            emit = 1'b1;
        end
    end

    // clear on END, else fold body byte, capture header, advance count or flag overflow
    always_comb
    begin
        crc_next = crc_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        for (int i = 0; i < slipcrc_pkg::HDR_N; i++)
        begin
            hdr_next[i] = hdr_reg[i];
        end
        if (clear)
        begin
            crc_next = slipcrc_pkg::CRC16_SEED;
            cnt_next = '0;
            ovf_next = 1'b0;
            for (int i = 0; i < slipcrc_pkg::HDR_N; i++)
            begin
                hdr_next[i] = 8'h00;
            end
        end
        else if (emit)
        begin
            crc_next = slipcrc_pkg::crc_fold(crc_reg, body_byte);
            for (int i = 0; i < slipcrc_pkg::HDR_N; i++)
            begin
                if (cnt_reg == slipcrc_pkg::CNT_W'(i + 1))
                begin
                    hdr_next[i] = body_byte;
                end
            end
            if (cnt_reg == slipcrc_pkg::CNT_W'(slipcrc_pkg::BUF_DEPTH))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        cnt_ext = slipcrc_pkg::CMP_W'(cnt_reg);
        if (cnt_ext > slipcrc_pkg::CMP_W'(slipcrc_pkg::LEN_CAP))
        begin
            len = slipcrc_pkg::LEN_W'(slipcrc_pkg::LEN_CAP);
        end
        else
        begin
            len = slipcrc_pkg::LEN_W'(cnt_ext);
        end
        priority if (hdr_reg[0] == slipcrc_pkg::TYPE_GET)
        begin
            cls = slipcrc_pkg::CLASS_GET;
        end
        else if (hdr_reg[0] == slipcrc_pkg::TYPE_NOTIFY)
        begin
            cls = slipcrc_pkg::CLASS_NOTIFY;
        end
        else if (hdr_reg[0] == slipcrc_pkg::TYPE_ACK)
        begin
            cls = slipcrc_pkg::CLASS_ACK;
        end
        else
        begin
            cls = slipcrc_pkg::CLASS_OTHER;
        end
    end

    always_comb
    begin
        res       = '0;
        res_valid = emit || report;
        if (report)
        begin
            res.kind           = slipcrc_pkg::KIND_REPORT;
            res.frame_ok       = (crc_reg == 16'h0000) && (cnt_reg >= slipcrc_pkg::CNT_W'(2))
                                 && !ovf_reg;
            res.frame_length   = len;
            res.msg_class      = cls;
            res.seq_number     = hdr_reg[1];
            res.opcode         = hdr_reg[2];
            res.payload_length = {hdr_reg[5], hdr_reg[4]};
            res.overflow       = ovf_reg;
        end
        else
        begin
            res.kind      = slipcrc_pkg::KIND_BYTE;
            res.data_byte = body_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= 1'b0;
            crc_reg <= slipcrc_pkg::CRC16_SEED;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            for (int i = 0; i < slipcrc_pkg::HDR_N; i++)
            begin
                hdr_reg[i] <= 8'h00;
            end
        end
        else if (step)
        begin
            esc_reg <= esc_next;
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            for (int i = 0; i < slipcrc_pkg::HDR_N; i++)
            begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= slipcrc_pkg::CNT_W'(slipcrc_pkg::BUF_DEPTH))
        else $error("body count beyond buffer depth");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (cnt_reg == slipcrc_pkg::CNT_W'(slipcrc_pkg::BUF_DEPTH)))
        else $error("overflow set with buffer not full");

    a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && report) |=> (cnt_reg == '0 && crc_reg == slipcrc_pkg::CRC16_SEED
                              && !ovf_reg && !esc_reg))
        else $error("frame state not cleared after report");

    a_esc_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !esc_reg && byte_in == slipcrc_pkg::SLIP_ESC) |-> !res_valid)
        else $error("escape byte produced a result");

endmodule

`default_nettype wire

@@ hw/rtl/slip_crc16_frame_receiver_top.sv @@
// Top level of the SLIP CRC-16 frame receiver: input register, frame logic, result register.
`timescale 1ns / 1ps
`default_nettype none

// Takes one raw serial byte per cycle unless in_stall is high and gives at most one result item
// per byte: a decoded body byte (result_kind 0) or, on an END that closes a non-empty body, a
// frame report (result_kind 1) with CRC-16/MODBUS verdict, length and header fields. Throughput
// is one item per clock while out_stall does not hold the result register; each byte passes the
// input register and the result register, with the CRC byte fold between them. Escape bytes,
// dropped escape pairs and END bytes closing an empty body produce no result.
module slip_crc16_frame_receiver_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      rx_byte,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 result_kind,
    output logic [7:0]                           data_byte,
    output logic                                 frame_ok,
    output logic [slipcrc_pkg::LEN_W-1:0]        frame_length,
    output logic [1:0]                           msg_class,
    output logic [7:0]                           seq_number,
    output logic [7:0]                           opcode,
    output logic [15:0]                          payload_length,
    output logic                                 overflow
);

    logic                   s1_valid_reg, s1_valid_next;
    logic [7:0]             s1_byte_reg;
    logic                   out_valid_reg, out_valid_next;
    slipcrc_pkg::result_t   out_res_reg;

    logic                   advance;
    logic                   step;
    logic                   res_valid;
    slipcrc_pkg::result_t   res;

    assign advance        = !out_valid_reg || !out_stall;
    assign in_stall       = s1_valid_reg && !advance;
    assign step           = s1_valid_reg && advance;
    assign s1_valid_next  = in_stall ? s1_valid_reg : in_valid;
    assign out_valid_next = advance ? (step && res_valid) : out_valid_reg;

    slipcrc_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_in   (s1_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payloads unless a new item lands
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (step && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = out_res_reg.kind;
    assign data_byte      = out_res_reg.data_byte;
    assign frame_ok       = out_res_reg.frame_ok;
    assign frame_length   = out_res_reg.frame_length;
    assign msg_class      = out_res_reg.msg_class;
    assign seq_number     = out_res_reg.seq_number;
    assign opcode         = out_res_reg.opcode;
    assign payload_length = out_res_reg.payload_length;
    assign overflow       = out_res_reg.overflow;

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with free stage");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_res_reg)))
        else $error("waiting result lost or changed");

    a_step_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !(in_valid && !in_stall)) |=> !s1_valid_reg)
        else $error("input stage kept an item it had passed on");

endmodule

`default_nettype wire
